// ----- rtl/x86_modrm_effective_address_macros.svh -----
// Assertion macros shared by the address generation RTL.
// Each expects clk and rst_n in the scope where it is used.
`ifndef X86_MODRM_EFFECTIVE_ADDRESS_MACROS_SVH
`define X86_MODRM_EFFECTIVE_ADDRESS_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define X86EA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("x86ea assertion failed");

// Next-cycle implication, checked outside reset.
`define X86EA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("x86ea assertion failed");

`endif

// ----- rtl/x86ea_pkg.sv -----
// Shared constants and types for the ModR/M effective address unit.
// No dependencies.
package x86ea_pkg;

    // Item opcodes
    localparam logic [1:0] OP_WR_GPR = 2'd0;
    localparam logic [1:0] OP_WR_SEG = 2'd1;
    localparam logic [1:0] OP_ADDR   = 2'd2;

    // Register file sizes
    localparam int unsigned NUM_GPR = 8;
    localparam int unsigned NUM_SEG = 6;

    // General register numbers
    localparam logic [2:0] GPR_EBX = 3'd3;
    localparam logic [2:0] GPR_ESP = 3'd4;
    localparam logic [2:0] GPR_EBP = 3'd5;
    localparam logic [2:0] GPR_ESI = 3'd6;
    localparam logic [2:0] GPR_EDI = 3'd7;

    // Segment numbers and the "use default" override code
    localparam logic [2:0] SEG_SS      = 3'd2;
    localparam logic [2:0] SEG_DS      = 3'd3;
    localparam logic [2:0] SEG_DEFAULT = 3'd6;

    // ModR/M mod field values
    localparam logic [1:0] MOD_MEM0  = 2'd0;
    localparam logic [1:0] MOD_DISP8 = 2'd1;
    localparam logic [1:0] MOD_DISPW = 2'd2;
    localparam logic [1:0] MOD_REG   = 2'd3;

    // Special rm / SIB codes
    localparam logic [2:0] RM_SIB       = 3'd4;
    localparam logic [2:0] RM16_DIRECT  = 3'd6;
    localparam logic [2:0] SIB_NO_INDEX = 3'd4;

    // Displacement kinds
    localparam logic [1:0] DISP_NONE = 2'd0;
    localparam logic [1:0] DISP_8    = 2'd1;
    localparam logic [1:0] DISP_16   = 2'd2;
    localparam logic [1:0] DISP_32   = 2'd3;

    // Decoded control carried from the input register to the adder stage
    typedef struct packed {
        logic       is_reg;
        logic [2:0] reg_sel;
        logic       a32;
        logic       use_a;
        logic       use_b;
        logic [1:0] scale;
        logic [1:0] disp_mode;
        logic [2:0] bytes_used;
    } ea_ctrl_t;

endpackage

// ----- rtl/x86ea_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module x86ea_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read ports, data held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a_reg <= mem[rd_addr_a];
            rd_data_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// ----- rtl/x86_modrm_effective_address.sv -----
// x86 ModR/M / SIB effective address unit; uses x86ea_pkg, x86ea_ram and the macro header.
// Pipeline: an accepted address request goes to the input stage register, then to the output
// register once that is free. Throughput: one item per cycle unless the output stalls;
// register files are written and read at the accept edge, so a write is visible to the very
// next item. Register writes produce no result. Reset (rst_n, async low) clears the pipeline
// valids, the segment file and the GPR valid bits, so every GPR reads as zero until written.
`include "x86_modrm_effective_address_macros.svh"
module x86_modrm_effective_address
    import x86ea_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [2:0]  reg_index,
    input  logic [31:0] reg_value,
    input  logic [7:0]  mod_rm,
    input  logic [7:0]  sib_byte,
    input  logic [31:0] disp_bytes,
    input  logic        address_32,
    input  logic [2:0]  seg_override,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] segment_value,
    output logic [31:0] offset,
    output logic [2:0]  bytes_used,
    output logic        is_register,
    output logic [2:0]  reg_select
);

    logic        in_transfer;
    logic        out_free;
    logic        gpr_we;
    logic        seg_we;

    logic [1:0]  mod_f;
    logic [2:0]  rm_f;
    logic [1:0]  sib_scale;
    logic [2:0]  sib_index;
    logic [2:0]  sib_base;
    logic        no_base;
    logic        ss_default;
    logic [2:0]  addr_a;
    logic [2:0]  addr_b;
    logic [2:0]  seg_sel;
    logic        use_a_raw;
    logic        use_b_raw;
    ea_ctrl_t    ctrl_d;

    logic [NUM_GPR-1:0] gpr_valid_reg;
    logic [15:0]        segment_regs_reg [NUM_SEG];
    logic [31:0]        rdata_a;
    logic [31:0]        rdata_b;

    logic        s1_valid_reg;
    ea_ctrl_t    s1_ctrl_reg;
    logic [31:0] s1_disp_reg;
    logic [15:0] s1_seg_reg;

    logic [31:0] a_val;
    logic [31:0] b_val;
    logic [31:0] d_val;
    logic [31:0] sum;
    logic [31:0] offset_next;
    logic [15:0] seg_next;

    logic        out_valid_reg;
    logic [15:0] segment_value_reg;
    logic [31:0] offset_reg;
    logic [2:0]  bytes_used_reg;
    logic        is_register_reg;
    logic [2:0]  reg_select_reg;

    // Handshake: the adder stage moves on whenever the output register is free
    assign out_free    = !out_valid_reg || out_ready;
    assign in_ready    = !s1_valid_reg || out_free;
    assign in_transfer = in_valid && in_ready;
    assign gpr_we      = in_transfer && (opcode == OP_WR_GPR);
    assign seg_we      = in_transfer && (opcode == OP_WR_SEG)
                         && (reg_index < SEG_DEFAULT);

    // Field split
    assign mod_f     = mod_rm[7:6];
    assign rm_f      = mod_rm[2:0];
    assign sib_scale = sib_byte[7:6];
    assign sib_index = sib_byte[5:3];
    assign sib_base  = sib_byte[2:0];

    // Address form decode: register reads, displacement kind, bytes, default segment
    always_comb
    begin
        ctrl_d     = '0;
        ctrl_d.a32 = address_32;
        addr_a     = rm_f;
        addr_b     = sib_index;
        use_a_raw  = 1'b0;
        use_b_raw  = 1'b0;
        no_base    = 1'b0;
        ss_default = 1'b0;

        if (mod_f == MOD_REG)
        begin
            ctrl_d.is_reg  = 1'b1;
            ctrl_d.reg_sel = rm_f;
        end
        else if (address_32)
        begin
            // base register and optional scaled index
            if (rm_f == RM_SIB)
            begin
                ctrl_d.bytes_used = 3'd1;
                ctrl_d.scale      = sib_scale;
                use_b_raw         = (sib_index != SIB_NO_INDEX);
                addr_a            = sib_base;
                if (sib_base == GPR_EBP && mod_f == MOD_MEM0)
                begin
                    no_base = 1'b1;
                end
                else
                begin
                    use_a_raw  = 1'b1;
                    ss_default = (sib_base == GPR_ESP) || (sib_base == GPR_EBP);
                end
            end
            else if (rm_f == GPR_EBP && mod_f == MOD_MEM0)
            begin
                no_base = 1'b1;
            end
            else
            begin
                use_a_raw  = 1'b1;
                ss_default = (rm_f == GPR_EBP);
            end

            // displacement
            unique case (mod_f)
                MOD_MEM0:
                begin
                    if (no_base)
                    begin
                        ctrl_d.disp_mode  = DISP_32;
                        ctrl_d.bytes_used = ctrl_d.bytes_used + 3'd4;
                    end
                end
                MOD_DISP8:
                begin
                    ctrl_d.disp_mode  = DISP_8;
                    ctrl_d.bytes_used = ctrl_d.bytes_used + 3'd1;
                end
                default:
                begin
                    ctrl_d.disp_mode  = DISP_32;
                    ctrl_d.bytes_used = ctrl_d.bytes_used + 3'd4;
                end
            endcase
        end
        else
        begin
            // 16-bit base/index pairs
            unique case (rm_f)
                3'd0:
                begin
                    addr_a = GPR_EBX; addr_b = GPR_ESI;
                    use_a_raw = 1'b1; use_b_raw = 1'b1;
                end
                3'd1:
                begin
                    addr_a = GPR_EBX; addr_b = GPR_EDI;
                    use_a_raw = 1'b1; use_b_raw = 1'b1;
                end
                3'd2:
                begin
                    addr_a = GPR_EBP; addr_b = GPR_ESI;
                    use_a_raw = 1'b1; use_b_raw = 1'b1; ss_default = 1'b1;
                end
                3'd3:
                begin
                    addr_a = GPR_EBP; addr_b = GPR_EDI;
                    use_a_raw = 1'b1; use_b_raw = 1'b1; ss_default = 1'b1;
                end
                3'd4:
                begin
                    addr_a = GPR_ESI; use_a_raw = 1'b1;
                end
                3'd5:
                begin
                    addr_a = GPR_EDI; use_a_raw = 1'b1;
                end
                3'd6:
                begin
                    addr_a = GPR_EBP;
                    if (mod_f != MOD_MEM0)
                    begin
                        use_a_raw  = 1'b1;
                        ss_default = 1'b1;
                    end
                end
                default:
                begin
                    addr_a = GPR_EBX; use_a_raw = 1'b1;
                end
            endcase

            // displacement: direct address form carries disp16 with mod 0
            unique case (mod_f)
                MOD_MEM0:
                begin
                    if (rm_f == RM16_DIRECT)
                    begin
                        ctrl_d.disp_mode  = DISP_16;
                        ctrl_d.bytes_used = 3'd2;
                    end
                end
                MOD_DISP8:
                begin
                    ctrl_d.disp_mode  = DISP_8;
                    ctrl_d.bytes_used = 3'd1;
                end
                default:
                begin
                    ctrl_d.disp_mode  = DISP_16;
                    ctrl_d.bytes_used = 3'd2;
                end
            endcase
        end

        // never-written registers read as zero
        ctrl_d.use_a = use_a_raw && gpr_valid_reg[addr_a];
        ctrl_d.use_b = use_b_raw && gpr_valid_reg[addr_b];
    end

    // Segment choice: override wins, codes 6 and 7 take the default
    assign seg_sel = (seg_override < SEG_DEFAULT) ? seg_override
                   : (ss_default ? SEG_SS : SEG_DS);

    // General register file
    x86ea_ram #(
        .WIDTH (32),
        .DEPTH (NUM_GPR)
    ) u_gpr_ram (
        .clk       (clk),
        .wr_en     (gpr_we),
        .wr_addr   (reg_index),
        .wr_data   (reg_value),
        .rd_en     (in_transfer),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .rd_data_a (rdata_a),
        .rd_data_b (rdata_b)
    );

    // GPR valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gpr_valid_reg <= '0;
        end
        else if (gpr_we)
        begin
            gpr_valid_reg[reg_index] <= 1'b1;
        end
    end

    // Segment register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SEG; i++)
            begin
                segment_regs_reg[i] <= '0;
            end
        end
        else if (seg_we)
        begin
            segment_regs_reg[reg_index] <= reg_value[15:0];
        end
    end

    // Input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid && (opcode == OP_ADDR);
        end
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (in_transfer)
        begin
            s1_ctrl_reg <= ctrl_d;
            s1_disp_reg <= disp_bytes;
            s1_seg_reg  <= segment_regs_reg[seg_sel];
        end
    end

    // Effective address: base + (index << scale) + displacement
    always_comb
    begin
        a_val = s1_ctrl_reg.use_a ? rdata_a : 32'd0;
        b_val = s1_ctrl_reg.use_b ? (rdata_b << s1_ctrl_reg.scale) : 32'd0;
        case (s1_ctrl_reg.disp_mode)
            DISP_8:  d_val = {{24{s1_disp_reg[7]}}, s1_disp_reg[7:0]};
            DISP_16: d_val = {16'd0, s1_disp_reg[15:0]};
            DISP_32: d_val = s1_disp_reg;
            default: d_val = 32'd0;
        endcase
        sum         = a_val + b_val + d_val;
        offset_next = s1_ctrl_reg.a32 ? sum : {16'd0, sum[15:0]};
        seg_next    = s1_ctrl_reg.is_reg ? 16'd0 : s1_seg_reg;
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            segment_value_reg <= seg_next;
            offset_reg        <= offset_next;
            bytes_used_reg    <= s1_ctrl_reg.bytes_used;
            is_register_reg   <= s1_ctrl_reg.is_reg;
            reg_select_reg    <= s1_ctrl_reg.reg_sel;
        end
    end

    assign out_valid     = out_valid_reg;
    assign segment_value = segment_value_reg;
    assign offset        = offset_reg;
    assign bytes_used    = bytes_used_reg;
    assign is_register   = is_register_reg;
    assign reg_select    = reg_select_reg;

    // Checks
    `X86EA_ASSERT_IMPL(a_reg_operand_zero, out_valid && is_register,
        segment_value == 16'd0 && offset == 32'd0 && bytes_used == 3'd0)
    `X86EA_ASSERT_IMPL(a_mem_operand_sel, out_valid && !is_register, reg_select == 3'd0)
    `X86EA_ASSERT_NEXT(a_stage_holds, s1_valid_reg && !out_free, s1_valid_reg)
    `X86EA_ASSERT_NEXT(a_gpr_valid_set, gpr_we, gpr_valid_reg[$past(reg_index)])

endmodule

// ----- bench/ea_result_checker.sv -----
// Result checker for the ModR/M effective address unit: mirrors both register files,
// predicts every address result and compares it with what leaves the block.
// Depends on x86ea_pkg.
`timescale 1ns / 1ps

module ea_result_checker
    import x86ea_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [2:0]         reg_index,
    input  logic [31:0]        reg_value,
    input  logic [7:0]         mod_rm,
    input  logic [7:0]         sib_byte,
    input  logic [31:0]        disp_bytes,
    input  logic               address_32,
    input  logic [2:0]         seg_override,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [15:0]        segment_value,
    input  logic [31:0]        offset,
    input  logic [2:0]         bytes_used,
    input  logic               is_register,
    input  logic [2:0]         reg_select,
    output int unsigned        error_count,
    output int unsigned        results_checked,
    output int unsigned        outstanding
);

    typedef struct packed {
        logic [15:0] seg_val;
        logic [31:0] ea_off;
        logic [2:0]  used;
        logic        is_reg;
        logic [2:0]  rsel;
    } ea_result_t;

    // Shadow copies of the block's register files
    logic [31:0] gpr_file [NUM_GPR];
    logic [15:0] seg_file [NUM_SEG];

    ea_result_t expected_ea[$];

    // Effective address for one request, from the current register files
    function automatic ea_result_t predict_ea(logic [7:0] modrm, logic [7:0] sib,
                                              logic [31:0] disp, logic a32,
                                              logic [2:0] ovr);
        ea_result_t  r;
        logic [1:0]  md;
        logic [2:0]  rm;
        logic [31:0] sum;
        logic [31:0] d8;
        logic [2:0]  seg;
        logic [2:0]  used;
        logic        no_base;
        logic [15:0] bx, bp16, si, di;
        logic [1:0]  sc;
        logic [2:0]  sidx;
        logic [2:0]  sbase;
        r  = '0;
        md = modrm[7:6];
        rm = modrm[2:0];
        if (md == MOD_REG)
        begin
            r.is_reg = 1'b1;
            r.rsel   = rm;
            return r;
        end
        d8      = {{24{disp[7]}}, disp[7:0]};
        seg     = SEG_DS;
        used    = '0;
        sum     = '0;
        no_base = 1'b0;
        if (!a32)
        begin
            bx   = gpr_file[GPR_EBX][15:0];
            bp16 = gpr_file[GPR_EBP][15:0];
            si   = gpr_file[GPR_ESI][15:0];
            di   = gpr_file[GPR_EDI][15:0];
            case (rm)
                3'd0: sum = 32'(bx) + 32'(si);
                3'd1: sum = 32'(bx) + 32'(di);
                3'd2: begin sum = 32'(bp16) + 32'(si); seg = SEG_SS; end
                3'd3: begin sum = 32'(bp16) + 32'(di); seg = SEG_SS; end
                3'd4: sum = 32'(si);
                3'd5: sum = 32'(di);
                RM16_DIRECT:
                begin
                    if (md != MOD_MEM0)
                    begin
                        sum = 32'(bp16);
                        seg = SEG_SS;
                    end
                end
                default: sum = 32'(bx);
            endcase
            case (md)
                MOD_MEM0:
                begin
                    if (rm == RM16_DIRECT)
                    begin
                        sum  = sum + 32'(disp[15:0]);
                        used = 3'd2;
                    end
                end
                MOD_DISP8:
                begin
                    sum  = sum + d8;
                    used = 3'd1;
                end
                default:
                begin
                    sum  = sum + 32'(disp[15:0]);
                    used = 3'd2;
                end
            endcase
            sum = {16'h0000, sum[15:0]};
        end
        else
        begin
            if (rm == RM_SIB)
            begin
                sc    = sib[7:6];
                sidx  = sib[5:3];
                sbase = sib[2:0];
                used  = 3'd1;
                if (sidx != SIB_NO_INDEX)
                    sum = gpr_file[sidx] << sc;
                // mod 0 with an EBP base means disp32 and no base register
                if (sbase == GPR_EBP && md == MOD_MEM0)
                    no_base = 1'b1;
                else
                begin
                    sum = sum + gpr_file[sbase];
                    if (sbase == GPR_ESP || sbase == GPR_EBP)
                        seg = SEG_SS;
                end
            end
            else if (rm == GPR_EBP && md == MOD_MEM0)
                no_base = 1'b1;
            else
            begin
                sum = gpr_file[rm];
                if (rm == GPR_EBP)
                    seg = SEG_SS;
            end
            case (md)
                MOD_MEM0:
                begin
                    if (no_base)
                    begin
                        sum  = sum + disp;
                        used = used + 3'd4;
                    end
                end
                MOD_DISP8:
                begin
                    sum  = sum + d8;
                    used = used + 3'd1;
                end
                default:
                begin
                    sum  = sum + disp;
                    used = used + 3'd4;
                end
            endcase
        end
        // codes 6 and 7 both keep the default segment
        if (ovr < SEG_DEFAULT)
            seg = ovr;
        r.seg_val = seg_file[seg];
        r.ea_off  = sum;
        r.used    = used;
        return r;
    endfunction

    task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
        error_count++;
    endtask

    // Compare outgoing transfers first, then fold in the incoming transfer
    always @(posedge clk or negedge rst_n)
    begin
        ea_result_t want;
        if (!rst_n)
        begin
            foreach (gpr_file[i]) gpr_file[i] = '0;
            foreach (seg_file[i]) seg_file[i] = '0;
            expected_ea.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_ea.size() == 0)
                begin
                    $display("%0t: unexpected result, offset 0x%0h segment 0x%0h",
                             $time, offset, segment_value);
                    error_count++;
                end
                else
                begin
                    want = expected_ea.pop_front();
                    results_checked++;
                    if (segment_value !== want.seg_val)
                        note_mismatch("segment_value", 32'(want.seg_val), 32'(segment_value));
                    if (offset !== want.ea_off)
                        note_mismatch("offset", want.ea_off, offset);
                    if (bytes_used !== want.used)
                        note_mismatch("bytes_used", 32'(want.used), 32'(bytes_used));
                    if (is_register !== want.is_reg)
                        note_mismatch("is_register", 32'(want.is_reg), 32'(is_register));
                    if (reg_select !== want.rsel)
                        note_mismatch("reg_select", 32'(want.rsel), 32'(reg_select));
                end
            end
            if (in_valid && in_ready)
            begin
                case (opcode)
                    OP_WR_GPR: gpr_file[reg_index] = reg_value;
                    OP_WR_SEG:
                    begin
                        if (reg_index < NUM_SEG)
                            seg_file[reg_index] = reg_value[15:0];
                    end
                    OP_ADDR:
                        expected_ea.push_back(predict_ea(mod_rm, sib_byte, disp_bytes,
                                                         address_32, seg_override));
                    default: ;
                endcase
            end
        end
        outstanding = expected_ea.size();
    end

endmodule

// ----- bench/tb.sv -----
// Testbench top for x86_modrm_effective_address: clock, reset, stimulus and verdict.
// Depends on x86ea_pkg, the block itself and ea_result_checker.
`timescale 1ns / 1ps

module tb;
    import x86ea_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int          HOLD_CYCLES = 150;
    localparam int          RAND_ITEMS  = 1370;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [2:0]  reg_index;
    logic [31:0] reg_value;
    logic [7:0]  mod_rm;
    logic [7:0]  sib_byte;
    logic [31:0] disp_bytes;
    logic        address_32;
    logic [2:0]  seg_override;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] segment_value;
    logic [31:0] offset;
    logic [2:0]  bytes_used;
    logic        is_register;
    logic [2:0]  reg_select;

    int unsigned error_count;
    int unsigned results_checked;
    int unsigned outstanding;

    int unsigned items_sent;
    int unsigned writes_sent;
    bit          steady_phase;
    bit          hold_off_req;

    x86_modrm_effective_address u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .reg_index     (reg_index),
        .reg_value     (reg_value),
        .mod_rm        (mod_rm),
        .sib_byte      (sib_byte),
        .disp_bytes    (disp_bytes),
        .address_32    (address_32),
        .seg_override  (seg_override),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .segment_value (segment_value),
        .offset        (offset),
        .bytes_used    (bytes_used),
        .is_register   (is_register),
        .reg_select    (reg_select)
    );

    ea_result_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .reg_index       (reg_index),
        .reg_value       (reg_value),
        .mod_rm          (mod_rm),
        .sib_byte        (sib_byte),
        .disp_bytes      (disp_bytes),
        .address_32      (address_32),
        .seg_override    (seg_override),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .segment_value   (segment_value),
        .offset          (offset),
        .bytes_used      (bytes_used),
        .is_register     (is_register),
        .reg_select      (reg_select),
        .error_count     (error_count),
        .results_checked (results_checked),
        .outstanding     (outstanding)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (steady_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // One input transfer; valid stays up across back-to-back items
    task automatic send_item(logic [1:0] op, logic [2:0] idx, logic [31:0] val,
                             logic [7:0] modrm, logic [7:0] sib, logic [31:0] disp,
                             logic a32, logic [2:0] ovr);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        reg_index    <= idx;
        reg_value    <= val;
        mod_rm       <= modrm;
        sib_byte     <= sib;
        disp_bytes   <= disp;
        address_32   <= a32;
        seg_override <= ovr;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        if (op == OP_WR_GPR || op == OP_WR_SEG)
            writes_sent++;
    endtask

    task automatic send_random_addr();
        logic [31:0] disp;
        logic [2:0]  ovr;
        case ($urandom_range(0, 3))
            0: disp = $urandom_range(0, 255);
            1: disp = {24'hFFFFFF, 8'($urandom_range(0, 255))};
            default: disp = $urandom();
        endcase
        ovr = ($urandom_range(0, 1) == 0) ? SEG_DEFAULT : 3'($urandom_range(0, 7));
        send_item(OP_ADDR, 3'($urandom_range(0, 7)), $urandom(),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  disp, 1'($urandom_range(0, 1)), ovr);
    endtask

    task automatic send_random_item();
        int          r;
        logic [31:0] val;
        r   = $urandom_range(0, 99);
        val = ($urandom_range(0, 2) == 0) ? ({16'($urandom_range(0, 65535)), 16'hFF00}
                                          | 32'($urandom_range(0, 255))) : $urandom();
        if (r < 15)
            send_item(OP_WR_GPR, 3'($urandom_range(0, 7)), val, 8'($urandom()),
                      8'($urandom()), $urandom(), 1'($urandom_range(0, 1)),
                      3'($urandom_range(0, 7)));
        else if (r < 23)
            send_item(OP_WR_SEG, 3'($urandom_range(0, 7)), val, 8'($urandom()),
                      8'($urandom()), $urandom(), 1'($urandom_range(0, 1)),
                      3'($urandom_range(0, 7)));
        else if (r < 25)
            send_item(OP_UNUSED, 3'($urandom_range(0, 7)), val, 8'($urandom()),
                      8'($urandom()), $urandom(), 1'($urandom_range(0, 1)),
                      3'($urandom_range(0, 7)));
        else
            send_random_addr();
    endtask

    // Receiver: random ready pattern, steady during the gap-free phase,
    // and one long hold-off on request
    initial
    begin
        int lvl;
        int dur;
        bit held;
        held = 1'b0;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_off_req && !held)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1'b1;
            end
            else if (steady_phase)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                lvl = ($urandom_range(0, 99) < 70);
                dur = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(1, 4);
                out_ready <= lvl[0];
                repeat (dur) @(posedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic [31:0] gpr_init [8];
        logic [15:0] seg_init [6];
        gpr_init = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'h0000_FFF0,
                     32'h7FFF_0010, 32'h0001_FF80, 32'h0000_0021, 32'hFFFF_8001};
        seg_init = '{16'h0000, 16'hFFFF, 16'h8001, 16'h1234, 16'h7FFE, 16'hA5A5};
        items_sent   = 0;
        writes_sent  = 0;
        steady_phase = 1'b0;
        hold_off_req = 1'b0;

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        opcode       <= OP_WR_GPR;
        reg_index    <= '0;
        reg_value    <= '0;
        mod_rm       <= '0;
        sib_byte     <= '0;
        disp_bytes   <= '0;
        address_32   <= 1'b0;
        seg_override <= SEG_DEFAULT;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: registers read zero straight out of reset
        send_item(OP_ADDR, '0, '0, {MOD_MEM0, 3'd0, 3'd0}, '0, '0, 1'b0, SEG_DEFAULT);
        foreach (gpr_init[i])
            send_item(OP_WR_GPR, 3'(i), gpr_init[i], '0, '0, '0, 1'b0, SEG_DEFAULT);
        // segment writes keep only the low half
        foreach (seg_init[i])
            send_item(OP_WR_SEG, 3'(i), {16'hDEAD, seg_init[i]}, '0, '0, '0, 1'b0,
                      SEG_DEFAULT);
        // segment numbers 6 and 7 and the spare opcode change nothing
        send_item(OP_WR_SEG, 3'd6, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, SEG_DEFAULT);
        send_item(OP_WR_SEG, 3'd7, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, SEG_DEFAULT);
        send_item(OP_UNUSED, 3'd3, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1,
                  3'd7);
        // register operand
        send_item(OP_ADDR, '0, '0, {MOD_REG, 3'd2, 3'd7}, 8'hFF, 32'hFFFF_FFFF, 1'b1, 3'd0);
        // 16-bit: direct disp16, BP+SI with negative disp8, BX+disp16 wrapping
        send_item(OP_ADDR, '0, '0, {MOD_MEM0, 3'd0, RM16_DIRECT}, '0, 32'h1234_ABCD, 1'b0,
                  SEG_DEFAULT);
        send_item(OP_ADDR, '0, '0, {MOD_DISP8, 3'd0, 3'd2}, '0, 32'h0000_0080, 1'b0,
                  SEG_DEFAULT);
        send_item(OP_ADDR, '0, '0, {MOD_DISPW, 3'd0, 3'd7}, '0, 32'h0000_FFFF, 1'b0, 3'd7);
        // 32-bit: plain disp32, SIB without base or index, scaled index, EBP base
        send_item(OP_ADDR, '0, '0, {MOD_MEM0, 3'd0, GPR_EBP}, '0, 32'hFFFF_FFFF, 1'b1, 3'd7);
        send_item(OP_ADDR, '0, '0, {MOD_MEM0, 3'd0, RM_SIB}, {2'd3, SIB_NO_INDEX, GPR_EBP},
                  32'h8000_0001, 1'b1, SEG_DEFAULT);
        send_item(OP_ADDR, '0, '0, {MOD_DISP8, 3'd0, RM_SIB}, {2'd3, 3'd2, GPR_ESP},
                  32'h0000_007F, 1'b1, 3'd5);
        send_item(OP_ADDR, '0, '0, {MOD_DISPW, 3'd0, GPR_EBP}, '0, 32'h8000_0000, 1'b1,
                  3'd0);

        // Random traffic, with a gap-free stretch and one long receiver hold-off
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == 400)
                steady_phase = 1'b1;
            if (n == 550)
                steady_phase = 1'b0;
            if (n == 800)
            begin
                hold_off_req = 1'b1;
                steady_phase = 1'b1;
                for (int k = 0; k < 40; k++)
                    send_random_addr();
                steady_phase = 1'b0;
            end
            send_random_item();
        end
        in_valid <= 1'b0;

        // Drain, then allow for the pipeline
        while (outstanding != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("summary: %0d transfers in (%0d register writes), %0d results compared",
                 items_sent, writes_sent, results_checked);
        $display("summary: 16/32-bit forms, SIB, overrides, register operands, stalls");
        if (error_count == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
